/* sv/npcm_pkg.sv */
// Package for the nearest palette color mapper.
// Holds command codes, color and pipeline control types, and the squared difference function.
// Depends on nothing.
`default_nettype none

package npcm_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned DIST_W  = 18;

  typedef enum logic [1:0] {
    CMD_LOAD_TGT = 2'd0,
    CMD_LOAD_SRC = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_MAP      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } ctl_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

/* sv/npcm_in_if.sv */
// Input channel of the nearest palette color mapper: valid, ready and the command payload.
// Depends on nothing.
`default_nettype none

interface npcm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] pixel_index;

  modport source (output valid, command, entry_index, red, green, blue, pixel_index,
                  input ready);
  modport sink (input valid, command, entry_index, red, green, blue, pixel_index,
                output ready);
endinterface

`default_nettype wire

/* sv/npcm_out_if.sv */
// Result channel of the nearest palette color mapper: valid, ready and the mapped index.
// Depends on nothing.
`default_nettype none

interface npcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mapped_index;
  logic       from_cache;

  modport source (output valid, mapped_index, from_cache, input ready);
  modport sink (input valid, mapped_index, from_cache, output ready);
endinterface

`default_nettype wire

/* sv/npcm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module npcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/npcm_dist.sv */
// Two stage squared RGB distance unit shared by every entry of a palette scan.
// Depends on npcm_pkg.
`default_nettype none

module npcm_dist (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire npcm_pkg::ctl_t  ctl_i,
  input  wire npcm_pkg::rgb_t  src_i,
  input  wire npcm_pkg::rgb_t  tgt_i,
  output      npcm_pkg::ctl_t  ctl_o,
  output      logic [17:0]     dist_o
);
  import npcm_pkg::*;

  ctl_t            ctl1_q;
  ctl_t            ctl2_q;
  logic [SQ_W-1:0] sq_r_q;
  logic [SQ_W-1:0] sq_g_q;
  logic [SQ_W-1:0] sq_b_q;
  logic [DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= sq_diff(src_i.red, tgt_i.red);
    sq_g_q <= sq_diff(src_i.green, tgt_i.green);
    sq_b_q <= sq_diff(src_i.blue, tgt_i.blue);
    dist_q <= DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  end

  assign ctl_o  = ctl2_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

/* sv/nearest_palette_color_mapper_unit.sv */
// Top level of the nearest palette color mapper: palette and cache memories, scan sequencer.
// Depends on npcm_pkg, npcm_in_if, npcm_out_if, npcm_ram and npcm_dist.
//
//   Channel   Direction  Handshake      Payload
//   in_i      sink       valid/ready    command, entry_index, red, green, blue, pixel_index
//   out_o     source     valid/ready    mapped_index, from_cache
//   cfg       sink       cfg_we_i       cfg_wdata_i (palette_count)
//
// Load and clear beats leave the block in S_IDLE, so it stays ready.
// A map beat that hits the cache passes S_CACHE and S_DONE; one that needs no search goes to S_DONE.
// A cache miss scans the target palette through one distance unit, one entry per cycle,
// passing S_SRC, S_SCAN, S_DRAIN and S_DONE; the block is not ready while the miss runs.
// A finished result waits in the output register while the next beat is accepted.
// Reset clears the cache valid bits at once; no clearing pass is needed.
`default_nettype none

module nearest_palette_color_mapper_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i,
  npcm_in_if.sink         in_i,
  npcm_out_if.source      out_o
);
  import npcm_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [COUNT_W-1:0] ENTRIES_C = COUNT_W'(PALETTE_ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRC   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_CACHE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   count_q;
  logic [COUNT_W-1:0]   count_sat;
  logic [PALETTE_ENTRIES-1:0] cvalid_q, cvalid_d;
  logic [AW-1:0]        ctr_q, ctr_d;
  logic [IDX_W-1:0]     pix_q, pix_d;
  rgb_t                 src_q, src_d;
  logic [DIST_W-1:0]    bestd_q, bestd_d;
  logic [IDX_W-1:0]     best_q, best_d;
  logic [IDX_W-1:0]     res_q, res_d;
  logic                 fc_q, fc_d;
  logic                 cw_q, cw_d;
  ctl_t                 ctl0_q, ctl0_d;
  logic                 out_valid_q, out_valid_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic                 out_fc_q, out_fc_d;

  logic                 accept;
  logic                 pix_ok;
  logic                 ent_ok;
  logic                 slot_free;
  logic                 cache_we;
  logic                 tgt_we;
  logic                 src_we;
  rgb_t                 load_rgb;
  rgb_t                 src_rdata;
  rgb_t                 tgt_rdata;
  logic [IDX_W-1:0]     cache_rdata;
  ctl_t                 dctl;
  logic [DIST_W-1:0]    ddist;
  logic                 take;
  logic [IDX_W-1:0]     pick_idx;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign pix_ok    = COUNT_W'(in_i.pixel_index) < ENTRIES_C;
  assign ent_ok    = COUNT_W'(in_i.entry_index) < ENTRIES_C;
  assign count_sat = (count_q > ENTRIES_C) ? ENTRIES_C : count_q;
  assign slot_free = !out_valid_q || out_o.ready;
  assign load_rgb  = '{red: in_i.red, green: in_i.green, blue: in_i.blue};
  assign tgt_we    = accept && (in_i.command == CMD_LOAD_TGT) && ent_ok;
  assign src_we    = accept && (in_i.command == CMD_LOAD_SRC) && ent_ok;
  assign cache_we  = (state_q == S_DONE) && slot_free && cw_q;

  npcm_ram #(.WIDTH($bits(rgb_t)), .DEPTH(PALETTE_ENTRIES)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (tgt_we),
    .waddr_i (in_i.entry_index[AW-1:0]),
    .wdata_i (load_rgb),
    .raddr_i (ctr_q),
    .rdata_o (tgt_rdata)
  );

  npcm_ram #(.WIDTH($bits(rgb_t)), .DEPTH(PALETTE_ENTRIES)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (in_i.entry_index[AW-1:0]),
    .wdata_i (load_rgb),
    .raddr_i (in_i.pixel_index[AW-1:0]),
    .rdata_o (src_rdata)
  );

  npcm_ram #(.WIDTH(IDX_W), .DEPTH(PALETTE_ENTRIES)) u_cache_ram (
    .clk_i   (clk_i),
    .we_i    (cache_we),
    .waddr_i (pix_q[AW-1:0]),
    .wdata_i (res_q),
    .raddr_i (in_i.pixel_index[AW-1:0]),
    .rdata_o (cache_rdata)
  );

  npcm_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl0_q),
    .src_i  (src_q),
    .tgt_i  (tgt_rdata),
    .ctl_o  (dctl),
    .dist_o (ddist)
  );

  assign take     = dctl.valid && (ddist <= bestd_q);
  assign pick_idx = take ? dctl.idx : best_q;

  always_comb begin
    state_d     = state_q;
    cvalid_d    = cvalid_q;
    ctr_d       = ctr_q;
    pix_d       = pix_q;
    src_d       = src_q;
    bestd_d     = take ? ddist : bestd_q;
    best_d      = pick_idx;
    res_d       = res_q;
    fc_d        = fc_q;
    cw_d        = cw_q;
    ctl0_d      = '0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_fc_d    = out_fc_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.command == CMD_CLEAR) begin
            cvalid_d = '0;
          end else if (in_i.command == CMD_MAP) begin
            pix_d = in_i.pixel_index;
            res_d = in_i.pixel_index;
            fc_d  = 1'b0;
            cw_d  = 1'b0;
            if (!pix_ok) begin
              state_d = S_DONE;
            end else if (cvalid_q[in_i.pixel_index[AW-1:0]]) begin
              state_d = S_CACHE;
            end else if (count_sat == '0) begin
              state_d = S_DONE;
            end else begin
              state_d = S_SRC;
            end
          end
        end
      end
      S_SRC: begin
        src_d   = src_rdata;
        ctr_d   = '0;
        bestd_d = '1;
        best_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        ctl0_d.valid = 1'b1;
        ctl0_d.idx   = IDX_W'(ctr_q);
        ctl0_d.last  = (COUNT_W'(ctr_q) == (count_sat - COUNT_W'(1)));
        ctr_d        = ctr_q + AW'(1);
        if (ctl0_d.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (dctl.valid && dctl.last) begin
          res_d   = pick_idx;
          fc_d    = 1'b0;
          cw_d    = 1'b1;
          state_d = S_DONE;
        end
      end
      S_CACHE: begin
        res_d   = cache_rdata;
        fc_d    = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_q;
          out_fc_d    = fc_q;
          if (cw_q) begin
            cvalid_d[pix_q[AW-1:0]] = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= ENTRIES_C;
      cvalid_q    <= '0;
      ctl0_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cvalid_q    <= cvalid_d;
      ctl0_q      <= ctl0_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q     <= ctr_d;
    pix_q     <= pix_d;
    src_q     <= src_d;
    bestd_q   <= bestd_d;
    best_q    <= best_d;
    res_q     <= res_d;
    fc_q      <= fc_d;
    cw_q      <= cw_d;
    out_idx_q <= out_idx_d;
    out_fc_q  <= out_fc_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mapped_index = out_idx_q;
  assign out_o.from_cache   = out_fc_q;

endmodule

`default_nettype wire

/* sv/npcm_checker.sv */
// Port level checker for the nearest palette color mapper, bound to the top level.
// Depends on npcm_pkg and nearest_palette_color_mapper_unit.
`default_nettype none

module npcm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic [1:0] in_command_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_mapped_index_i,
  input wire logic       out_from_cache_i
);
  import npcm_pkg::*;

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_mapped_index_i)
      && $stable(out_from_cache_i))
    else $error("result beat changed while stalled");

  a_map_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_command_i == CMD_MAP) |=> !in_ready_i)
    else $error("ready stayed high after a map beat");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_command_i != CMD_MAP) && !out_valid_i |=> !out_valid_i)
    else $error("result appeared after a load or clear beat");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while the block was idle");

endmodule

bind nearest_palette_color_mapper_unit npcm_checker u_npcm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_command_i       (in_i.command),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_mapped_index_i (out_o.mapped_index),
  .out_from_cache_i   (out_o.from_cache)
);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for nearest_palette_color_mapper_unit: loads both palettes, drives
// load, clear and map beats under random bursts and stalls, and checks every mapped result.
// Depends on npcm_pkg, npcm_in_if, npcm_out_if and the mapper RTL.
`default_nettype none

module testbench;
  import npcm_pkg::*;

  localparam int unsigned PAL_DEPTH    = 256;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    cmd_e       command;
    logic [7:0] entry_index;
    rgb_t       color;
    logic [7:0] pixel_index;
  } pal_beat_t;

  typedef struct {
    logic [7:0] mapped_index;
    logic       from_cache;
  } map_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [8:0] cfg_wdata_i;

  npcm_in_if  pix_in ();
  npcm_out_if map_out ();

  nearest_palette_color_mapper_unit #(
    .PALETTE_ENTRIES(PAL_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (pix_in),
    .out_o      (map_out)
  );

  rgb_t        tgt_colors [PAL_DEPTH];
  rgb_t        src_colors [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] memo_valid = '0;
  logic [7:0]  memo_index [PAL_DEPTH];
  logic [8:0]  count_model = 9'd256;
  map_result_t pending_maps [$];

  int errors        = 0;
  int beats_sent    = 0;
  int maps_checked  = 0;
  int cache_hits    = 0;
  int settings_used = 0;
  int burst_left    = 0;
  int hold_off_cycles = 0;

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned color_distance(input rgb_t a, input rgb_t b);
    int unsigned dr;
    int unsigned dg;
    int unsigned db;
    dr = (a.red > b.red) ? a.red - b.red : b.red - a.red;
    dg = (a.green > b.green) ? a.green - b.green : b.green - a.green;
    db = (a.blue > b.blue) ? a.blue - b.blue : b.blue - a.blue;
    return dr * dr + dg * dg + db * db;
  endfunction

  function automatic void apply_beat(input pal_beat_t b);
    map_result_t r;
    int unsigned limit;
    int unsigned bestd;
    int unsigned d;
    int unsigned best;
    case (b.command)
      CMD_LOAD_TGT: begin
        tgt_colors[b.entry_index] = b.color;
      end
      CMD_LOAD_SRC: begin
        src_colors[b.entry_index] = b.color;
      end
      CMD_CLEAR: begin
        memo_valid = '0;
      end
      default: begin
        r.mapped_index = b.pixel_index;
        r.from_cache = 1'b0;
        if (memo_valid[b.pixel_index]) begin
          r.mapped_index = memo_index[b.pixel_index];
          r.from_cache = 1'b1;
        end else begin
          limit = (count_model > PAL_DEPTH) ? PAL_DEPTH : count_model;
          if (limit != 0) begin
            bestd = 32'hFFFF_FFFF;
            best = 0;
            for (int unsigned i = 0; i < limit; i++) begin
              d = color_distance(src_colors[b.pixel_index], tgt_colors[i]);
              if (d <= bestd) begin
                bestd = d;
                best = i;
              end
            end
            memo_valid[b.pixel_index] = 1'b1;
            memo_index[b.pixel_index] = best[7:0];
            r.mapped_index = best[7:0];
          end
        end
        pending_maps.push_back(r);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin : scoreboard
    map_result_t want;
    pal_beat_t seen;
    if (rst_ni && map_out.valid && map_out.ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result, mapped_index %0d from_cache %0b", $time,
                 map_out.mapped_index, map_out.from_cache);
        errors++;
      end else begin
        want = pending_maps.pop_front();
        maps_checked++;
        if (want.from_cache) cache_hits++;
        if (map_out.mapped_index !== want.mapped_index) begin
          $display("%0t: mapped_index expected %0d, actual %0d", $time,
                   want.mapped_index, map_out.mapped_index);
          errors++;
        end
        if (map_out.from_cache !== want.from_cache) begin
          $display("%0t: from_cache expected %0b, actual %0b", $time,
                   want.from_cache, map_out.from_cache);
          errors++;
        end
      end
    end
    if (rst_ni && pix_in.valid && pix_in.ready) begin
      seen.command = cmd_e'(pix_in.command);
      seen.entry_index = pix_in.entry_index;
      seen.color = {pix_in.red, pix_in.green, pix_in.blue};
      seen.pixel_index = pix_in.pixel_index;
      apply_beat(seen);
    end
  end

  initial begin : result_sink
    int hold_left;
    int mode;
    int mode_left;
    int cyc;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    map_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_off_cycles > 0) begin
        hold_left = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        map_out.ready <= 1'b0;
      end else begin
        case (mode)
          0: map_out.ready <= 1'b1;
          1: map_out.ready <= ($urandom_range(0, 3) != 0);
          2: map_out.ready <= ($urandom_range(0, 3) == 0);
          default: map_out.ready <= ((cyc % 16) >= 5);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((pix_in.valid && pix_in.ready) || (map_out.valid && map_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic send_beat(input pal_beat_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix_in.valid       <= 1'b1;
    pix_in.command     <= b.command;
    pix_in.entry_index <= b.entry_index;
    pix_in.red         <= b.color.red;
    pix_in.green       <= b.color.green;
    pix_in.blue        <= b.color.blue;
    pix_in.pixel_index <= b.pixel_index;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  function automatic pal_beat_t random_beat(input cmd_e c);
    pal_beat_t b;
    b.command = c;
    b.entry_index = 8'($urandom_range(0, 255));
    b.color = rgb_t'(24'($urandom_range(0, 24'hFF_FFFF)));
    b.pixel_index = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_load(input cmd_e c, input logic [7:0] slot, input rgb_t col);
    pal_beat_t b;
    b = random_beat(c);
    b.entry_index = slot;
    b.color = col;
    send_beat(b);
  endtask

  task automatic send_map(input logic [7:0] pix);
    pal_beat_t b;
    b = random_beat(CMD_MAP);
    b.pixel_index = pix;
    send_beat(b);
  endtask

  task automatic send_clear();
    send_beat(random_beat(CMD_CLEAR));
  endtask

  task automatic settle();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_palette_count(input logic [8:0] n);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_model = n;
    settings_used++;
  endtask

  task automatic test_fill_palettes();
    for (int i = 0; i < PAL_DEPTH; i++) begin
      send_load(CMD_LOAD_TGT, i[7:0], rgb_t'(24'($urandom_range(0, 24'hFF_FFFF))));
    end
    for (int i = 0; i < PAL_DEPTH; i++) begin
      send_load(CMD_LOAD_SRC, i[7:0], rgb_t'(24'($urandom_range(0, 24'hFF_FFFF))));
    end
  endtask

  task automatic test_directed();
    set_palette_count(9'd2);
    send_load(CMD_LOAD_TGT, 8'd0, 24'hFF00FF);
    send_load(CMD_LOAD_TGT, 8'd1, 24'hFF00FF);
    send_load(CMD_LOAD_SRC, 8'd5, 24'hFA03FA);
    send_load(CMD_LOAD_SRC, 8'd0, 24'h000000);
    send_load(CMD_LOAD_SRC, 8'd255, 24'hFFFFFF);
    send_clear();
    send_map(8'd5);
    send_map(8'd5);
    // Reloading a target entry must not disturb what the cache already holds.
    send_load(CMD_LOAD_TGT, 8'd1, 24'h000000);
    send_map(8'd5);
    send_clear();
    send_map(8'd5);
    send_map(8'd0);
    set_palette_count(9'd0);
    send_map(8'd5);
    send_map(8'd255);
    send_map(8'd7);
    set_palette_count(9'd511);
    send_load(CMD_LOAD_TGT, 8'd255, 24'hFFFFFF);
    send_clear();
    send_map(8'd255);
    send_map(8'd255);
    set_palette_count(9'd256);
    send_clear();
    send_map(8'd255);
    send_map(8'd0);
  endtask

  task automatic test_backpressure();
    set_palette_count(9'd8);
    hold_off_cycles = 400;
    repeat (40) begin
      if ($urandom_range(0, 5) == 0) begin
        send_clear();
      end else begin
        send_map(8'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic run_random_phase(input logic [8:0] n, input int beats);
    logic [7:0] pool [12];
    int pick;
    set_palette_count(n);
    foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_load(CMD_LOAD_TGT,
                  8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 255)),
                  rgb_t'(24'($urandom_range(0, 24'hFF_FFFF))));
      end else if (pick < 20) begin
        send_load(CMD_LOAD_SRC,
                  ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 11)]
                                              : 8'($urandom_range(0, 255)),
                  rgb_t'(24'($urandom_range(0, 24'hFF_FFFF))));
      end else if (pick < 24) begin
        send_clear();
      end else if (pick < 30) begin
        send_map(8'($urandom_range(0, 255)));
      end else begin
        send_map(pool[$urandom_range(0, 11)]);
      end
    end
  endtask

  task automatic test_random_phases();
    logic [8:0] counts [12];
    counts = '{9'd1, 9'd2, 9'd3, 9'd0, 9'd256, 9'd255, 9'd511, 9'd300,
               9'd16, 9'd64, 9'd7, 9'd0};
    counts[11] = 9'($urandom_range(1, 40));
    foreach (counts[k]) run_random_phase(counts[k], 115);
  endtask

  initial begin : test_sequence
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= 9'd0;
    pix_in.valid       <= 1'b0;
    pix_in.command     <= CMD_LOAD_TGT;
    pix_in.entry_index <= 8'd0;
    pix_in.red         <= 8'd0;
    pix_in.green       <= 8'd0;
    pix_in.blue        <= 8'd0;
    pix_in.pixel_index <= 8'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_palettes();
    test_directed();
    test_backpressure();
    test_random_phases();
    settle();
    $display("Sent %0d beats across %0d palette_count settings.", beats_sent, settings_used);
    $display("Checked %0d mapped pixels, %0d of them served from the cache.",
             maps_checked, cache_hits);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
